>>> rtl/mhts_pkg.sv
package mhts_pkg;

   localparam int NUM_TEMPLATES = 64;
   localparam int SYMBOLS       = 32;

   localparam int GRAM_W        = 64;
   localparam int CFG_W         = 64;
   localparam int CSR_IDX_W     = 8;
   localparam int IDX_W         = 6;
   localparam int DIST_W        = 6;
   localparam int RSP_DATA_W    = 16;

   // rank of a free bit position, saturated at the number of deposited index bits
   localparam int DEP_BITS      = IDX_W;
   localparam int RANK_W        = 3;
   localparam int SUM_W         = 5;
   // template index widened so that every saturated rank selects a bit
   localparam int JEXT_W        = 2 ** RANK_W;

   // free-position prefix count and match count both work in groups of eight bits
   localparam int GROUP_W       = 8;
   localparam int GROUP_CNT_W   = 4;
   localparam int BYTE_GROUPS   = GRAM_W / GROUP_W;
   localparam int NUM_GROUPS    = (SYMBOLS + GROUP_W - 1) / GROUP_W;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = 2;
   localparam int FIFO_CNT_W    = 3;

   typedef logic [GRAM_W-1:0] gram_type;
   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [RANK_W-1:0] rank_type;

   localparam dist_type NO_MATCH  = DIST_W'(SYMBOLS + 1);
   localparam dist_type SYM_COUNT = DIST_W'(SYMBOLS);
   localparam rank_type RANK_SAT  = RANK_W'(DEP_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MASK_ONE = 8'd0,
      REG_MASK_TWO = 8'd1,
      REG_PART_ONE = 8'd2,
      REG_PART_TWO = 8'd3
   } csr_reg_type;

   typedef struct packed {
      gram_type gram;
      logic     end_of_scan;
   } item_type;

   typedef struct packed {
      gram_type                base;
      gram_type                free_pos;
      rank_type [GRAM_W-1:0]   rank;
   } tmpl_cfg_type;

   typedef struct packed {
      logic                            load;
      dist_type [NUM_TEMPLATES-1:0]    minima;
   } scan_done_type;

endpackage

>>> rtl/mhts_front.sv
module mhts_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mhts_pkg::gram_type    req_tdata,
   input  logic                  req_tuser,
   output mhts_pkg::item_type    item,
   output logic                  item_valid,
   input  logic                  item_take
);
   import mhts_pkg::*;

   item_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    push, pop;

   assign req_tready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign push       = req_tvalid & req_tready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_valid & item_take;
   assign item       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{gram: req_tdata, end_of_scan: req_tuser};
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count above depth");
   a_push_pop_hold: assert property (@(posedge clock) disable iff (reset)
      (push && pop) |=> $stable(count_ff))
      else $error("queue count moved on simultaneous push and pop");
`endif

endmodule

>>> rtl/mhts_tmpl.sv
module mhts_tmpl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [mhts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mhts_pkg::CFG_W-1:0]       csr_wdata,
   output mhts_pkg::tmpl_cfg_type           tmpl_cfg
);
   import mhts_pkg::*;

   gram_type                  mask_one_ff, mask_two_ff, part_one_ff, part_two_ff;

   gram_type                  base_a_ff, base_a_in;
   gram_type                  free_a_ff, free_a_in;
   logic [GROUP_CNT_W-1:0]    local_a_ff [GRAM_W];
   logic [GROUP_CNT_W-1:0]    local_a_in [GRAM_W];
   logic [GROUP_CNT_W-1:0]    total_a_ff [BYTE_GROUPS];
   logic [GROUP_CNT_W-1:0]    total_a_in [BYTE_GROUPS];

   gram_type                  base_b_ff, free_b_ff;
   rank_type                  rank_b_ff [GRAM_W];
   rank_type                  rank_b_in [GRAM_W];

   function automatic rank_type sat_rank(input logic [SUM_W-1:0] v);
      return (v >= SUM_W'(RANK_SAT)) ? RANK_SAT : v[RANK_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_one_ff <= '0;
         mask_two_ff <= '0;
         part_one_ff <= '0;
         part_two_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_MASK_ONE: mask_one_ff <= csr_wdata;
            REG_MASK_TWO: mask_two_ff <= csr_wdata;
            REG_PART_ONE: part_one_ff <= csr_wdata;
            REG_PART_TWO: part_two_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // first step: base, free positions and per-byte exclusive prefix counts
   always_comb begin
      logic [GROUP_CNT_W-1:0] acc;
      base_a_in = (part_one_ff & mask_one_ff) | (part_two_ff & mask_two_ff);
      free_a_in = ~(mask_one_ff | mask_two_ff);
      for (int g = 0; g < BYTE_GROUPS; g++) begin
         acc = '0;
         for (int k = 0; k < GROUP_W; k++) begin
            local_a_in[g*GROUP_W+k] = acc;
            acc = acc + GROUP_CNT_W'(free_a_in[g*GROUP_W+k]);
         end
         total_a_in[g] = acc;
      end
   end

   // second step: add the byte offsets, saturate at the deposit width
   always_comb begin
      rank_type off;
      off = '0;
      for (int g = 0; g < BYTE_GROUPS; g++) begin
         for (int k = 0; k < GROUP_W; k++) begin
            rank_b_in[g*GROUP_W+k] =
               sat_rank(SUM_W'(off) + SUM_W'(local_a_ff[g*GROUP_W+k]));
         end
         off = sat_rank(SUM_W'(off) + SUM_W'(total_a_ff[g]));
      end
   end

   always_ff @(posedge clock) begin
      base_a_ff  <= base_a_in;
      free_a_ff  <= free_a_in;
      local_a_ff <= local_a_in;
      total_a_ff <= total_a_in;
      base_b_ff  <= base_a_ff;
      free_b_ff  <= free_a_ff;
      rank_b_ff  <= rank_b_in;
   end

   always_comb begin
      tmpl_cfg.base     = base_b_ff;
      tmpl_cfg.free_pos = free_b_ff;
      for (int p = 0; p < GRAM_W; p++) begin
         tmpl_cfg.rank[p] = rank_b_ff[p];
      end
   end

endmodule

>>> rtl/mhts_back.sv
module mhts_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mhts_pkg::item_type       item,
   input  logic                     item_valid,
   output logic                     item_take,
   input  mhts_pkg::tmpl_cfg_type   tmpl_cfg,
   input  logic                     can_load,
   output mhts_pkg::scan_done_type  done
);
   import mhts_pkg::*;

   logic                      s1_valid_ff, s1_eos_ff;
   gram_type                  s1_gram_ff;
   logic                      s2_valid_ff, s2_eos_ff;
   logic [SYMBOLS-1:0]        s2_same_ff [NUM_TEMPLATES];
   logic [SYMBOLS-1:0]        s2_same_in [NUM_TEMPLATES];
   logic                      s3_valid_ff, s3_eos_ff;
   logic [GROUP_CNT_W-1:0]    s3_cnt_ff [NUM_TEMPLATES][NUM_GROUPS];
   logic [GROUP_CNT_W-1:0]    s3_cnt_in [NUM_TEMPLATES][NUM_GROUPS];
   dist_type                  min_ff [NUM_TEMPLATES];
   dist_type                  min_in [NUM_TEMPLATES];
   dist_type                  new_min [NUM_TEMPLATES];
   logic                      stall, advance, update;

   // hold the whole pipe while a finished scan waits for the report line
   assign stall     = s3_valid_ff & s3_eos_ff & ~can_load;
   assign advance   = ~stall;
   assign item_take = advance;
   assign update    = advance & s3_valid_ff;

   // form every template and compare it with the gram symbol by symbol
   always_comb begin
      logic [JEXT_W-1:0] jext;
      gram_type          tmpl;
      for (int j = 0; j < NUM_TEMPLATES; j++) begin
         jext = JEXT_W'(j);
         for (int p = 0; p < GRAM_W; p++) begin
            tmpl[p] = tmpl_cfg.base[p] |
                      (tmpl_cfg.free_pos[p] & jext[tmpl_cfg.rank[p]]);
         end
         for (int s = 0; s < SYMBOLS; s++) begin
            s2_same_in[j][s] = (s1_gram_ff[2*s +: 2] == tmpl[2*s +: 2]);
         end
      end
   end

   always_comb begin
      logic [GROUP_CNT_W-1:0] acc;
      for (int j = 0; j < NUM_TEMPLATES; j++) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            acc = '0;
            for (int k = 0; k < GROUP_W; k++) begin
               if (g*GROUP_W + k < SYMBOLS) begin
                  acc = acc + GROUP_CNT_W'(s2_same_ff[j][g*GROUP_W+k]);
               end
            end
            s3_cnt_in[j][g] = acc;
         end
      end
   end

   always_comb begin
      dist_type match;
      dist_type distance;
      for (int j = 0; j < NUM_TEMPLATES; j++) begin
         match = '0;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            match = match + DIST_W'(s3_cnt_ff[j][g]);
         end
         distance   = SYM_COUNT - match;
         new_min[j] = (distance < min_ff[j]) ? distance : min_ff[j];
         min_in[j]  = min_ff[j];
         if (update) begin
            min_in[j] = s3_eos_ff ? NO_MATCH : new_min[j];
         end
      end
   end

   always_comb begin
      done.load = update & s3_eos_ff;
      for (int j = 0; j < NUM_TEMPLATES; j++) begin
         done.minima[j] = new_min[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_TEMPLATES; j++) begin
            min_ff[j] <= NO_MATCH;
         end
      end else begin
         if (advance) begin
            s1_valid_ff <= item_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         min_ff <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_gram_ff <= item.gram;
         s1_eos_ff  <= item.end_of_scan;
         s2_eos_ff  <= s1_eos_ff;
         s2_same_ff <= s2_same_in;
         s3_eos_ff  <= s2_eos_ff;
         s3_cnt_ff  <= s3_cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      done.load |-> can_load)
      else $error("scan report loaded while the report line is busy");
   a_plain_never_stalls: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_eos_ff) |-> advance)
      else $error("pipe held on an ordinary gram");
   a_stall_holds_eos: assert property (@(posedge clock) disable iff (reset)
      stall |=> (s3_valid_ff && s3_eos_ff))
      else $error("finished scan lost during a stall");
`endif

endmodule

>>> rtl/mhts_report.sv
module mhts_report (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mhts_pkg::scan_done_type              done,
   output logic                                 can_load,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mhts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import mhts_pkg::*;

   logic                busy_ff, busy_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   dist_type            line_ff [NUM_TEMPLATES];
   logic                xfer, last;

   assign xfer       = rsp_tvalid & rsp_tready;
   assign last       = (idx_ff == IDX_W'(NUM_TEMPLATES - 1));
   assign can_load   = ~busy_ff | (xfer & last);
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {(RSP_DATA_W - IDX_W - DIST_W)'(0), line_ff[0], idx_ff};

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (done.load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (xfer) begin
         idx_in = idx_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // snapshot all minima, then shift one toward the head per transfer
   always_ff @(posedge clock) begin
      if (done.load) begin
         for (int j = 0; j < NUM_TEMPLATES; j++) begin
            line_ff[j] <= done.minima[j];
         end
      end else if (xfer) begin
         for (int j = 0; j < NUM_TEMPLATES - 1; j++) begin
            line_ff[j] <= line_ff[j+1];
         end
      end
   end

`ifndef ASSERT_OFF
   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      done.load |=> (rsp_tvalid && idx_ff == '0))
      else $error("report run did not start at template zero");
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (xfer && last && !done.load) |=> !rsp_tvalid)
      else $error("result offered after the last template");
`endif

endmodule

>>> rtl/min_hamming_template_scan_core.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | tdata: gram; tuser: end_of_scan
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: template_index, min_distance;
//         |           |                        | tlast: last_result
// csr     | in        | csr_wen (no wait)      | csr_index, csr_wdata
//
// One gram per cycle enters unless held; each passes a 4-deep queue and a 3-stage
// compare pipe in which all 64 templates are matched in parallel, the minima update on
// leaving it. A gram marked end of scan loads a 64-entry report line that drains one
// result per rsp transfer; an end-of-scan gram coming while it drains holds the pipe at s3.
// Reset is synchronous: control registers go to 0, every minimum to 33, no clearing pass.
// Templates follow a register write via the template steps; rsp stalls back up the queue.
module min_hamming_template_scan_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mhts_pkg::GRAM_W-1:0]          req_tdata,  // [63:0] gram
   input  logic                                 req_tuser,  // [0] end_of_scan
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mhts_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [5:0] template_index,
                                                            // [11:6] min_distance
   output logic                                 rsp_tlast,
   input  logic                                 csr_wen,
   input  logic [mhts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mhts_pkg::CFG_W-1:0]           csr_wdata
);
   import mhts_pkg::*;

   item_type        item;
   logic            item_valid;
   logic            item_take;
   tmpl_cfg_type    tmpl_cfg;
   scan_done_type   done;
   logic            can_load;

   mhts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   mhts_tmpl u_tmpl (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tmpl_cfg  (tmpl_cfg)
   );

   mhts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .tmpl_cfg   (tmpl_cfg),
      .can_load   (can_load),
      .done       (done)
   );

   mhts_report u_report (
      .clock      (clock),
      .reset      (reset),
      .done       (done),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
